/* rtl/lph_pkg.sv */
package lph_pkg;

	localparam int KEY_W = 64;
	localparam int VAL_W = 32;
	localparam int STATUS_W = 3;
	localparam int OCC_W = 7;
	localparam int SLOTS = 64;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_REPLACED = 3'd1,
		ST_REMOVED  = 3'd2,
		ST_HIT      = 3'd3,
		ST_MISS     = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		HS_OAAT = 2'd0,
		HS_DJB2 = 2'd1,
		HS_SDBM = 2'd2,
		HS_SUM  = 2'd3
	} hash_sel_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VAL_W-1:0]    found_value;
		logic [OCC_W-1:0]    occupancy;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HASH,
		S_FRD,
		S_FCHK,
		S_WRITE,
		S_JRD,
		S_JHASH,
		S_JCHK,
		S_DONE
	} state_t;

endpackage

/* rtl/linear_probe_hash_table.sv */
// Linear-probing hash table with backward-shift deletion.
// Requests come on start/request while busy is low; a request is taken at
// the rising edge where start is high and busy is low. Commands are insert
// or replace, remove, and lookup. Exactly one response follows each request:
// done is high for a single cycle with response valid. The receiver cannot
// stall, so the response must be captured in that cycle.
// Each hash runs in the shared byte-serial hash unit, one key byte per step
// (plus a final mixing step for one-at-a-time); then each probed slot is
// read and compared in turn. Remove also rehashes every entry of the cluster
// behind the removed slot, one hash per slot. busy stays high for the whole
// command. hash_sel is written through cfg_we/cfg_data; the user must write
// it only while idle, which the block does not enforce. Reset selects djb2.
// After reset the valid bits and the entry count are zero; key and value
// storage is not cleared.
module linear_probe_hash_table
	import lph_pkg::*;
#(
	parameter int KEY_BYTES = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  req_t       request,
	output logic       busy,
	output logic       done,
	output rsp_t       response,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW = $clog2(SLOTS + 1);
	localparam logic [KEY_W-1:0] KMASK = (KEY_BYTES >= 8) ? '1 :
		KEY_W'((64'd1 << (8 * KEY_BYTES)) - 64'd1);
	localparam logic [VAL_W-1:0] VMASK = (VALUE_BITS >= 32) ? '1 :
		VAL_W'((64'd1 << VALUE_BITS) - 64'd1);

	state_t state_q, state_d;
	logic [1:0] hsel_q;
	logic [1:0] cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [AW-1:0] idx_q, gap_q;
	logic [NW-1:0] n_q;
	logic [OCC_W-1:0] count_q;
	logic [SLOTS-1:0] valid_q;
	logic [STATUS_W-1:0] st_q;
	logic [VAL_W-1:0] fv_q;

	logic [KEY_W-1:0] kmem [SLOTS];
	logic [VAL_W-1:0] vmem [SLOTS];
	logic [KEY_W-1:0] rk_q;
	logic [VAL_W-1:0] rv_q;

	logic hstart;
	logic hbusy;
	logic [KEY_W-1:0] hkey;
	logic [63:0] hash;
	logic [AW-1:0] home;

	// Memory command from the sequencer.
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [KEY_W-1:0] wr_key;
	logic [VAL_W-1:0] wr_val;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
		return (32'(i) + 1 >= SLOTS) ? '0 : AW'(32'(i) + 1);
	endfunction

	function automatic logic [AW:0] dst(input logic [AW-1:0] a, input logic [AW-1:0] b);
		return (b >= a) ? (AW+1)'(b - a) : (AW+1)'(32'(b) + SLOTS - 32'(a));
	endfunction

	assign home = AW'(hash % 64'(SLOTS));

	lph_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(hstart), .sel(hsel_q),
		.key(hkey), .busy(hbusy), .hash(hash)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			kmem[wr_addr] <= wr_key;
			vmem[wr_addr] <= wr_val;
		end
		if (rd_en) begin
			rk_q <= kmem[rd_addr];
			rv_q <= vmem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hsel_q <= HS_DJB2;
		end else begin
			state_q <= state_d;
			if (cfg_we) hsel_q <= cfg_data;
		end
	end

	// The hash output holds once the unit goes idle, so the home of the
	// candidate entry is read straight from it.
	logic moving;
	logic [AW:0] dh;
	assign dh = dst(gap_q, home);
	assign moving = (dh == '0) || (dh > dst(gap_q, idx_q));

	always_comb begin
		state_d = state_q;
		hstart = 1'b0;
		hkey = key_q;
		rd_en = 1'b0;
		rd_addr = idx_q;
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_key = key_q;
		wr_val = val_q;
		case (state_q)
			S_IDLE: if (start) begin
				hstart = 1'b1;
				hkey = request.key & KMASK;
				state_d = S_HASH;
			end
			S_HASH: if (!hbusy) state_d = S_FRD;
			S_FRD: begin
				if (n_q == NW'(SLOTS)) state_d = S_WRITE;
				else if (!valid_q[idx_q]) state_d = S_WRITE;
				else begin
					rd_en = 1'b1;
					state_d = S_FCHK;
				end
			end
			S_FCHK: state_d = (rk_q == key_q) ? S_WRITE : S_FRD;
			S_WRITE: begin
				if (st_q == ST_INSERTED || st_q == ST_REPLACED) wr_en = 1'b1;
				state_d = (st_q == ST_REMOVED) ? S_JRD : S_DONE;
			end
			S_JRD: begin
				if (n_q == NW'(SLOTS) || !valid_q[idx_q]) state_d = S_DONE;
				else begin
					rd_en = 1'b1;
					state_d = S_JHASH;
				end
			end
			S_JHASH: begin
				hstart = 1'b1;
				hkey = rk_q;
				state_d = S_JCHK;
			end
			S_JCHK: if (!hbusy) begin
				if (moving) begin
					wr_en = 1'b1;
					wr_addr = gap_q;
					wr_key = rk_q;
					wr_val = rv_q;
				end
				state_d = S_JRD;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath registers; status is settled at the probe end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				S_WRITE: begin
					if (st_q == ST_INSERTED) begin
						valid_q[idx_q] <= 1'b1;
						count_q <= count_q + 1'b1;
					end else if (st_q == ST_REMOVED) begin
						valid_q[idx_q] <= 1'b0;
						if (count_q != '0) count_q <= count_q - 1'b1;
					end
				end
				S_JCHK: if (!hbusy && moving) begin
					valid_q <= (valid_q | (SLOTS'(1) << gap_q)) & ~(SLOTS'(1) << idx_q);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= request.command;
				key_q <= request.key & KMASK;
				val_q <= request.value & VMASK;
				n_q <= '0;
				fv_q <= '0;
			end
			S_HASH: if (!hbusy) idx_q <= home;
			S_FRD: begin
				if (n_q == NW'(SLOTS)) begin
					st_q <= (cmd_q == CMD_INSERT) ? ST_FULL : ST_MISS;
				end else if (!valid_q[idx_q]) begin
					st_q <= (cmd_q == CMD_INSERT) ? ST_INSERTED : ST_MISS;
				end
			end
			S_FCHK: begin
				if (rk_q == key_q) begin
					case (cmd_q)
						CMD_INSERT: st_q <= ST_REPLACED;
						CMD_REMOVE: st_q <= ST_REMOVED;
						CMD_LOOKUP: begin
							st_q <= ST_HIT;
							fv_q <= rv_q;
						end
						default: st_q <= ST_MISS;
					endcase
				end else begin
					idx_q <= nxt(idx_q);
					n_q <= n_q + 1'b1;
				end
			end
			S_WRITE: begin
				gap_q <= idx_q;
				idx_q <= nxt(idx_q);
				n_q <= NW'(1);
			end
			S_JCHK: if (!hbusy) begin
				if (moving) gap_q <= idx_q;
				idx_q <= nxt(idx_q);
				n_q <= n_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign response = '{status: st_q, found_value: fv_q, occupancy: count_q};

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= SLOTS) else $error("occupancy above slot count");

endmodule

/* rtl/lph_hash.sv */
module lph_hash
	import lph_pkg::*;
#(
	parameter int KEY_BYTES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       sel,
	input  logic [KEY_W-1:0] key,
	output logic             busy,
	output logic [63:0]      hash
);

	localparam int CW = $clog2(KEY_BYTES + 4);

	logic [63:0]      h_q;
	logic [KEY_W-1:0] key_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [1:0]       sel_q;
	logic [63:0]      h_step;
	logic [63:0]      t;
	logic [7:0]       b;
	logic             in_bytes;

	// Byte steps come first, then one final mixing step for one-at-a-time.
	assign in_bytes = cnt_q < CW'(KEY_BYTES);
	assign b = key_q[8*KEY_BYTES-1 -: 8];

	always_comb begin
		t = '0;
		h_step = h_q;
		if (in_bytes) begin
			case (sel_q)
				HS_OAAT: begin
					t = h_q + 64'(b);
					t = t + (t << 10);
					h_step = t ^ (t >> 6);
				end
				HS_DJB2: h_step = (h_q << 5) + h_q + 64'(b);
				HS_SDBM: h_step = 64'(b) + (h_q << 6) + (h_q << 16) - h_q;
				default: h_step = h_q + 64'(b);
			endcase
		end else begin
			t = h_q + (h_q << 3);
			t = t ^ (t >> 11);
			h_step = t + (t << 15);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (in_bytes && (cnt_q != CW'(KEY_BYTES - 1) || sel_q == HS_OAAT)) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!in_bytes) begin
				cnt_q <= '0;
				busy_q <= 1'b0;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= (sel == HS_DJB2) ? 64'd5381 : 64'd0;
			key_q <= key;
			sel_q <= sel;
		end else if (busy_q) begin
			h_q <= h_step;
			key_q <= key_q << 8;
		end
	end

	assign busy = busy_q;
	assign hash = h_q;

endmodule
